>>> rtl/core/tlbc_pkg.sv
package tlbc_pkg;

  // field widths of one request and one result
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;

  // entries_in_use register
  localparam int              CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // request: page to translate and the frame from the table walk
  typedef struct packed {
    logic [PAGE_BITS-1:0]  virtual_page;
    logic [FRAME_BITS-1:0] walk_frame;
  } tlbc_req_t;

  // result: translated frame and hit flag
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
  } tlbc_rsp_t;

  // one stored translation
  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tlbc_entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_WRITE
  } tlbc_state_e;

endpackage

>>> rtl/core/tlbc_ram.sv
module tlbc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tlbc_ctrl.sv
module tlbc_ctrl import tlbc_pkg::*; #(
  parameter int TLB_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tlbc_req_t                      req_i,
  input  logic [$clog2(TLB_DEPTH+1)-1:0] n_i,
  output logic                           done_o,
  output tlbc_rsp_t                      rsp_o,
  output logic                           ram_we_o,
  output logic [$clog2(TLB_DEPTH)-1:0]   ram_waddr_o,
  output tlbc_entry_t                    ram_wdata_o,
  output logic [$clog2(TLB_DEPTH)-1:0]   ram_raddr_o,
  input  tlbc_entry_t                    ram_rdata_i
);

  localparam int IDX_W = $clog2(TLB_DEPTH);
  localparam int CNT_W = $clog2(TLB_DEPTH+1);

  tlbc_state_e            state_q, state_d;
  logic [IDX_W-1:0]       chk_q, chk_d;
  logic [IDX_W-1:0]       hand_q, hand_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic                   free_q, free_d;
  logic [TLB_DEPTH-1:0]   valid_q, valid_d;
  logic [TLB_DEPTH-1:0]   used_q, used_d;
  logic                   done_q, done_d;
  tlbc_req_t              req_q, req_d;
  tlbc_rsp_t              rsp_q, rsp_d;
  logic                   hit_now;
  logic                   chk_last;
  logic                   hand_last;

  // compare of the entry whose data the ram returns this cycle
  assign hit_now   = valid_q[chk_q] && (ram_rdata_i.page == req_q.virtual_page);
  assign chk_last  = (CNT_W'(chk_q) + CNT_W'(1)) == n_i;
  assign hand_last = (CNT_W'(hand_q) + CNT_W'(1)) == n_i;

  // sequencer: search one entry a cycle; on a miss, sweep the hand if no entry is free, then fill
  always_comb begin
    state_d     = state_q;
    chk_d       = chk_q;
    hand_d      = hand_q;
    slot_d      = slot_q;
    free_d      = free_q;
    valid_d     = valid_q;
    used_d      = used_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    ram_we_o    = 1'b0;
    ram_raddr_o = chk_q + IDX_W'(1);
    case (state_q)
      ST_IDLE: begin
        ram_raddr_o = '0;
        if (start) begin
          req_d   = req_i;
          chk_d   = '0;
          free_d  = 1'b0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_now) begin
          used_d[chk_q] = 1'b1;
          rsp_d.frame   = ram_rdata_i.frame;
          rsp_d.hit     = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          // last invalid entry seen is the highest-indexed one
          if (!valid_q[chk_q]) begin
            free_d = 1'b1;
            slot_d = chk_q;
          end
          if (chk_last) begin
            if (free_d) begin
              state_d = ST_WRITE;
            end else begin
              // hand left beyond a lowered entry count wraps to zero
              if (CNT_W'(hand_q) >= n_i) begin
                hand_d = '0;
              end
              state_d = ST_SWEEP;
            end
          end else begin
            chk_d = chk_q + IDX_W'(1);
          end
        end
      end
      ST_SWEEP: begin
        if (used_q[hand_q]) begin
          used_d[hand_q] = 1'b0;
          hand_d         = hand_last ? '0 : hand_q + IDX_W'(1);
        end else begin
          slot_d  = hand_q;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we_o        = 1'b1;
        valid_d[slot_q] = 1'b1;
        used_d[slot_q]  = 1'b1;
        rsp_d.frame     = req_q.walk_frame;
        rsp_d.hit       = 1'b0;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_q   <= '0;
      hand_q  <= '0;
      slot_q  <= '0;
      free_q  <= 1'b0;
      valid_q <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      hand_q  <= hand_d;
      slot_q  <= slot_d;
      free_q  <= free_d;
      valid_q <= valid_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy                  = (state_q != ST_IDLE);
  assign done_o                = done_q;
  assign rsp_o                 = rsp_q;
  assign ram_waddr_o           = slot_q;
  assign ram_wdata_o.page      = req_q.virtual_page;
  assign ram_wdata_o.frame     = req_q.walk_frame;

  // result strobe follows a working state and coincides with the return to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) != ST_IDLE) && !busy)
    else $error("result strobe outside a finished request");

  // a filled entry is valid and used afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> valid_q[$past(slot_q)] && used_q[$past(slot_q)])
    else $error("filled entry not marked valid and used");

  // the hand stays inside the active entries while sweeping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (CNT_W'(hand_q) < n_i))
    else $error("clock hand beyond active entries");

  // the sweep only starts when every active entry is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !free_q)
    else $error("sweep started with a free entry");

endmodule

>>> rtl/core/tlb_clock_replacement.sv
// fully associative tlb with clock replacement, one request at a time
// with n active entries: a hit strobes once the search reaches its entry, a miss with a free
// entry fills it, and a miss that sweeps clears used bits (at most n) before the fill
// throughput: busy until the result; the next request is taken in the strobe cycle
// the result strobe lasts one cycle and the receiver cannot stall it
// reset: all entries invalid, hand at entry 0, entries_in_use 16, no clearing pass
module tlb_clock_replacement import tlbc_pkg::*; #(
  parameter int TLB_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tlbc_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output tlbc_rsp_t        rsp_o
);

  localparam int IDX_W = $clog2(TLB_DEPTH);
  localparam int CNT_W = $clog2(TLB_DEPTH+1);

  logic [CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] n_active;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  tlbc_entry_t      ram_wdata;
  tlbc_entry_t      ram_rdata;

  // entries_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // zero counts as one, values above the depth count as the depth
  always_comb begin
    if (cfg_q == '0) begin
      n_active = CNT_W'(1);
    end else if (int'(cfg_q) > TLB_DEPTH) begin
      n_active = CNT_W'(TLB_DEPTH);
    end else begin
      n_active = CNT_W'(cfg_q);
    end
  end

  // page and frame storage
  tlbc_ram #(
    .WIDTH ($bits(tlbc_entry_t)),
    .DEPTH (TLB_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search, sweep and fill sequencer
  tlbc_ctrl #(
    .TLB_DEPTH (TLB_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .n_i         (n_active),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

>>> test/tb_top.sv
module tb_top;
  import tlbc_pkg::*;

  localparam int DEPTH     = 16;
  localparam int POOL_MAX  = 24;
  localparam int DIR_ROWS  = 22;
  localparam int CFG_STEPS = 9;
  localparam int PER_CFG   = 60;

  // directed row: request plus an optional hand-written expectation
  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] walk;
    logic                  typed;
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  tlbc_req_t        req_i;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             done_o;
  tlbc_rsp_t        rsp_o;

  // shadow copy of the tlb contents
  logic                  sh_valid [DEPTH];
  logic                  sh_used  [DEPTH];
  logic [PAGE_BITS-1:0]  sh_page  [DEPTH];
  logic [FRAME_BITS-1:0] sh_frame [DEPTH];
  logic [3:0]            sh_hand;
  logic [CFG_W-1:0]      sh_entries;

  tlbc_rsp_t            pending_xlat [$];
  logic [PAGE_BITS-1:0] page_pool [$];
  int                   mismatches;

  dir_row_t         dir_tab [DIR_ROWS];
  logic [CFG_W-1:0] cfg_plan [CFG_STEPS];

  tlb_clock_replacement uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // clock, period 8
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // translate one request and update the shadow tlb
  function automatic tlbc_rsp_t predict_translation(tlbc_req_t r);
    tlbc_rsp_t res;
    int        n;
    int        free_idx;
    int        steps;
    int        nxt;
    n = (sh_entries == 0) ? 1 : ((sh_entries > DEPTH) ? DEPTH : int'(sh_entries));
    free_idx = -1;
    // associative search, remembering the highest invalid entry
    for (int i = 0; i < n; i++) begin
      if (sh_valid[i] && sh_page[i] == r.virtual_page) begin
        sh_used[i] = 1'b1;
        res.frame = sh_frame[i];
        res.hit = 1'b1;
        return res;
      end
      if (!sh_valid[i]) free_idx = i;
    end
    // no free entry: clock sweep clears used bits until a victim shows up
    if (free_idx < 0) begin
      if (sh_hand >= n) sh_hand = '0;
      steps = 0;
      while (steps <= n && sh_used[sh_hand]) begin
        sh_used[sh_hand] = 1'b0;
        nxt = (int'(sh_hand) + 1) % n;
        sh_hand = nxt[3:0];
        steps++;
      end
      free_idx = int'(sh_hand);
    end
    sh_valid[free_idx] = 1'b1;
    sh_used[free_idx] = 1'b1;
    sh_page[free_idx] = r.virtual_page;
    sh_frame[free_idx] = r.walk_frame;
    res.frame = r.walk_frame;
    res.hit = 1'b0;
    return res;
  endfunction

  // present one request and wait for it to be taken
  task automatic issue_req(input logic [PAGE_BITS-1:0] pg, input logic [FRAME_BITS-1:0] wf,
                           input logic typed, input tlbc_rsp_t typed_rsp);
    tlbc_req_t r;
    tlbc_rsp_t p;
    r.virtual_page = pg;
    r.walk_frame = wf;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = predict_translation(r);
    pending_xlat.push_back(typed ? typed_rsp : p);
  endtask

  // random sender idle cycles
  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      while ($urandom_range(99) < pct) @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_entries(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_entries = v;
  endtask

  // random page: mostly recent pages so hits and evictions happen
  task automatic random_req(input int pct);
    logic [PAGE_BITS-1:0] pg;
    int                   win;
    win = int'(sh_entries) + 3;
    if (win > page_pool.size()) win = page_pool.size();
    if (win != 0 && $urandom_range(99) < 55) begin
      pg = page_pool[page_pool.size() - 1 - $urandom_range(win - 1)];
    end else begin
      pg = PAGE_BITS'($urandom_range(20'hFFFFF));
      page_pool.push_back(pg);
      if (page_pool.size() > POOL_MAX) void'(page_pool.pop_front());
    end
    sender_gap(pct);
    issue_req(pg, FRAME_BITS'($urandom_range(20'hFFFFF)), 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    tlbc_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_xlat.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: frame %h hit %b", rsp_o.frame, rsp_o.hit);
      end else begin
        want = pending_xlat.pop_front();
        if (rsp_o.frame !== want.frame || rsp_o.hit !== want.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected frame %h hit %b, got frame %h hit %b",
                     want.frame, want.hit, rsp_o.frame, rsp_o.hit);
        end
      end
    end
  end

  // stimulus
  initial begin
    tlbc_rsp_t tr;
    int        pct;
    mismatches = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sh_valid[i] = 1'b0;
      sh_used[i] = 1'b0;
      sh_page[i] = '0;
      sh_frame[i] = '0;
    end
    sh_hand = '0;
    sh_entries = CFG_RESET;

    // extremes, refills, hits, then a full table that forces the sweep
    dir_tab[0]  = '{20'h00000, 20'hFFFFF, 1'b1, 20'hFFFFF, 1'b0};
    dir_tab[1]  = '{20'hFFFFF, 20'h00000, 1'b1, 20'h00000, 1'b0};
    dir_tab[2]  = '{20'h00000, 20'h12345, 1'b1, 20'hFFFFF, 1'b1};
    dir_tab[3]  = '{20'hFFFFF, 20'hABCDE, 1'b1, 20'h00000, 1'b1};
    dir_tab[4]  = '{20'hAAAAA, 20'h55555, 1'b1, 20'h55555, 1'b0};
    dir_tab[5]  = '{20'h55555, 20'hAAAAA, 1'b1, 20'hAAAAA, 1'b0};
    dir_tab[6]  = '{20'h00001, 20'h10001, 1'b0, 20'h0, 1'b0};
    dir_tab[7]  = '{20'h00002, 20'h10002, 1'b0, 20'h0, 1'b0};
    dir_tab[8]  = '{20'h00003, 20'h10003, 1'b0, 20'h0, 1'b0};
    dir_tab[9]  = '{20'h00004, 20'h10004, 1'b0, 20'h0, 1'b0};
    dir_tab[10] = '{20'h00005, 20'h10005, 1'b0, 20'h0, 1'b0};
    dir_tab[11] = '{20'h00006, 20'h10006, 1'b0, 20'h0, 1'b0};
    dir_tab[12] = '{20'h00007, 20'h10007, 1'b0, 20'h0, 1'b0};
    dir_tab[13] = '{20'h00008, 20'h10008, 1'b0, 20'h0, 1'b0};
    dir_tab[14] = '{20'h00009, 20'h10009, 1'b0, 20'h0, 1'b0};
    dir_tab[15] = '{20'h0000A, 20'h1000A, 1'b0, 20'h0, 1'b0};
    dir_tab[16] = '{20'h0000B, 20'h1000B, 1'b0, 20'h0, 1'b0};
    dir_tab[17] = '{20'h0000C, 20'h1000C, 1'b0, 20'h0, 1'b0};
    dir_tab[18] = '{20'h00000, 20'h00000, 1'b0, 20'h0, 1'b0};
    dir_tab[19] = '{20'h80000, 20'h7FFFF, 1'b0, 20'h0, 1'b0};
    dir_tab[20] = '{20'h40000, 20'hFFFFE, 1'b0, 20'h0, 1'b0};
    dir_tab[21] = '{20'h55555, 20'h00001, 1'b0, 20'h0, 1'b0};

    // the plan lowers the count first, which can leave the hand beyond the searched entries
    cfg_plan[0] = 5'd4;
    cfg_plan[1] = 5'd0;
    cfg_plan[2] = 5'd31;
    cfg_plan[3] = 5'd1;
    cfg_plan[4] = 5'd2;
    cfg_plan[5] = 5'd17;
    cfg_plan[6] = 5'd3;
    cfg_plan[7] = 5'd16;
    cfg_plan[8] = CFG_W'($urandom_range(31));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset setting
    for (int i = 0; i < DIR_ROWS; i++) begin
      tr.frame = dir_tab[i].frame;
      tr.hit = dir_tab[i].hit;
      issue_req(dir_tab[i].page, dir_tab[i].walk, dir_tab[i].typed, tr);
    end

    // random part: three idle profiles, three settings each
    for (int s = 0; s < CFG_STEPS; s++) begin
      pct = (s < 3) ? 19 : ((s < 6) ? 69 : 0);
      write_entries(cfg_plan[s]);
      for (int k = 0; k < PER_CFG; k++) begin
        if ($urandom_range(99) < 3) drain_results();
        random_req(pct);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_xlat.size() == 0) begin
      $display("[tlb_clock_replacement] OK");
    end else begin
      $display("[tlb_clock_replacement] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("[tlb_clock_replacement] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/tlbc_pkg.sv
rtl/core/tlbc_ram.sv
rtl/core/tlbc_ctrl.sv
rtl/core/tlb_clock_replacement.sv
test/tb_top.sv
